[rtl/core/mrs_pkg.sv]
// Package for the Modbus RTU register slave: types, constants and CRC helper.
`default_nettype none
package mrs_pkg;
    localparam int RegCount   = 16;
    localparam int FrameDepth = 64;
    localparam int RegIdxW    = 4;
    localparam int FrameIdxW  = 6;
    localparam int CountW     = 7;

    localparam logic [7:0]  FN_READ   = 8'h03;
    localparam logic [7:0]  FN_WRITE  = 8'h06;
    localparam logic [7:0]  EXC_FLAG  = 8'h80;
    localparam logic [7:0]  EXC_FUNC  = 8'h01;
    localparam logic [7:0]  EXC_ADDR  = 8'h02;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  ADDR_RST  = 8'h01;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_GAP  = 2'd1;
    localparam logic [1:0] KIND_HOST = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  rx_byte;
        logic [3:0]  host_index;
        logic [15:0] host_value;
    } t_in;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_out;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE,
        ST_HDR1, ST_HDR2, ST_HDR3, ST_HDR4, ST_HDR5, ST_DECIDE,
        ST_EMIT_ADDR, ST_EMIT_FN, ST_EMIT_CODE,
        ST_EMIT_CNT, ST_RD_REQ, ST_RD_HI, ST_RD_LO,
        ST_WR_ECHO,
        ST_CRC_LO, ST_CRC_HI
    } t_state;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction
endpackage
`default_nettype wire

[rtl/core/modbus_rtu_register_slave.sv]
// Modbus RTU slave; frame store and holding-register table are two synchronous memories.
// A received byte, host write or rejected gap is handled without leaving IDLE; a gap
// whose count and CRC pass but whose byte 0 misses the address returns from HDR1 to
// IDLE. A matching frame passes HDR1 to HDR5 and DECIDE for the header, then sends one
// reply byte per cycle unless the output stalls, plus an RD_REQ state per register read.
// After reset a clearing pass zeros the frame store and table, with no item taken.
`default_nettype none
module modbus_rtu_register_slave (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire mrs_pkg::t_in    i_data,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output mrs_pkg::t_out        o_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [7:0]      i_cfg_data
);
    import mrs_pkg::*;

    logic [7:0]  r_frame [FrameDepth];
    logic [15:0] r_table [RegCount];

    t_state           r_state, n_state;
    logic [7:0]       r_own;
    logic [CountW-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_tcrc, n_tcrc;
    logic [7:0]       r_fn, n_fn;
    logic [15:0]      r_a, n_a;
    logic [15:0]      r_b, n_b;
    logic [7:0]       r_code, n_code;
    logic [CountW-1:0] r_pos, n_pos;
    logic [15:0]      r_left, n_left;
    logic [FrameIdxW:0] r_clr, n_clr;
    logic [7:0]       r_frd;
    logic [15:0]      r_trd;
    logic             r_ovalid, n_ovalid;
    t_out             r_odata, n_odata;

    logic                 f_we;
    logic [FrameIdxW-1:0] f_wa, f_ra;
    logic [7:0]           f_wd;
    logic                 t_we;
    logic [RegIdxW-1:0]   t_wa, t_ra;
    logic [15:0]          t_wd;

    logic accept, out_free, emit;
    logic [7:0] e_byte;
    logic       e_last;

    assign out_free    = !r_ovalid || !i_stall;
    assign o_stall     = (r_state != ST_IDLE);
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_data      = r_odata;

    always_ff @(posedge i_clk) begin
        if (f_we) r_frame[f_wa] <= f_wd;
        r_frd <= r_frame[f_ra];
        if (t_we) r_table[t_wa] <= t_wd;
        r_trd <= r_table[t_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_own    <= ADDR_RST;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_crc    <= CRC_INIT;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_valid) r_own <= i_cfg_data;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_crc    <= n_crc;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tcrc  <= n_tcrc;
        r_fn    <= n_fn;
        r_a     <= n_a;
        r_b     <= n_b;
        r_code  <= n_code;
        r_pos   <= n_pos;
        r_left  <= n_left;
        r_odata <= n_odata;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_crc    = r_crc;
        n_tcrc   = r_tcrc;
        n_fn     = r_fn;
        n_a      = r_a;
        n_b      = r_b;
        n_code   = r_code;
        n_pos    = r_pos;
        n_left   = r_left;
        n_clr    = r_clr;
        n_ovalid = r_ovalid && i_stall;
        n_odata  = r_odata;
        f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
        t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = r_a[RegIdxW-1:0];
        emit = 1'b0; e_byte = '0; e_last = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                f_we = 1'b1; f_wa = r_clr[FrameIdxW-1:0];
                t_we = 1'b1; t_wa = r_clr[RegIdxW-1:0];
                n_clr = r_clr + 1'b1;
                if (r_clr == (FrameIdxW+1)'(FrameDepth - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                f_ra = '0;
                if (accept) begin
                    unique case (i_data.kind)
                        KIND_BYTE: begin
                            if (r_count < CountW'(FrameDepth)) begin
                                f_we = 1'b1; f_wa = r_count[FrameIdxW-1:0];
                                f_wd = i_data.rx_byte;
                                n_count = r_count + 1'b1;
                                n_crc = crc_byte(r_crc, i_data.rx_byte);
                            end else n_ovf = 1'b1;
                        end
                        KIND_GAP: begin
                            // byte 0 is read now, so hold for the check
                            if (r_count >= CountW'(4) && r_count < CountW'(FrameDepth)
                                && !r_ovf && r_crc == 16'h0000) begin
                                n_state = ST_HDR1;
                            end
                            n_count = '0; n_ovf = 1'b0; n_crc = CRC_INIT;
                        end
                        KIND_HOST: begin
                            t_we = 1'b1; t_wa = i_data.host_index;
                            t_wd = i_data.host_value;
                        end
                        default: ;
                    endcase
                end
            end
            // r_frd in HDR1 holds byte 0 (read issued at the accepting edge)
            ST_HDR1: begin
                f_ra = 6'd1;
                n_state = (r_frd == r_own) ? ST_HDR2 : ST_IDLE;
            end
            ST_HDR2: begin n_fn = r_frd; f_ra = 6'd2; n_state = ST_HDR3; end
            ST_HDR3: begin n_a[15:8] = r_frd; f_ra = 6'd3; n_state = ST_HDR4; end
            ST_HDR4: begin n_a[7:0] = r_frd; f_ra = 6'd4; n_state = ST_HDR5; end
            ST_HDR5: begin n_b[15:8] = r_frd; f_ra = 6'd5; n_state = ST_DECIDE; end
            ST_DECIDE: begin
                n_b[7:0] = r_frd;
                n_tcrc = CRC_INIT;
                n_pos = '0;
                n_code = '0;
                if (r_fn == FN_READ) begin
                    if ({1'b0, r_a} + {9'b0, r_frd} + {1'b0, r_b[15:8], 8'h00}
                        > 17'(RegCount)) n_code = EXC_ADDR;
                end else if (r_fn == FN_WRITE) begin
                    if (r_a >= 16'(RegCount)) n_code = EXC_ADDR;
                end else n_code = EXC_FUNC;
                n_state = ST_EMIT_ADDR;
            end
            ST_EMIT_ADDR: begin
                emit = 1'b1; e_byte = r_own;
                if (out_free) n_state = ST_EMIT_FN;
            end
            ST_EMIT_FN: begin
                emit = 1'b1;
                e_byte = (r_code != '0) ? (r_fn | EXC_FLAG) : r_fn;
                if (out_free) begin
                    if (r_code != '0) n_state = ST_EMIT_CODE;
                    else if (r_fn == FN_READ) n_state = ST_EMIT_CNT;
                    else begin
                        n_state = ST_WR_ECHO;
                        n_left = 16'd2;
                    end
                end
            end
            ST_EMIT_CODE: begin
                emit = 1'b1; e_byte = r_code;
                if (out_free) n_state = ST_CRC_LO;
            end
            ST_EMIT_CNT: begin
                emit = 1'b1; e_byte = {r_b[6:0], 1'b0};
                if (out_free) begin
                    n_left = r_b;
                    n_state = (r_b == '0) ? ST_CRC_LO : ST_RD_REQ;
                end
            end
            ST_RD_REQ: begin
                t_ra = r_a[RegIdxW-1:0];
                n_state = ST_RD_HI;
            end
            ST_RD_HI: begin
                t_ra = r_a[RegIdxW-1:0];
                emit = 1'b1; e_byte = r_trd[15:8];
                if (out_free) n_state = ST_RD_LO;
            end
            ST_RD_LO: begin
                t_ra = r_a[RegIdxW-1:0];
                emit = 1'b1; e_byte = r_trd[7:0];
                if (out_free) begin
                    n_a = r_a + 1'b1;
                    n_left = r_left - 1'b1;
                    n_state = (r_left == 16'd1) ? ST_CRC_LO : ST_RD_REQ;
                end
            end
            ST_WR_ECHO: begin
                emit = 1'b1;
                // echo a_hi, a_lo, b_hi, b_lo by shifting
                e_byte = r_a[15:8];
                if (out_free) begin
                    n_a = {r_a[7:0], r_b[15:8]};
                    n_b = {r_b[7:0], 8'h00};
                    if (n_left == 16'd2 && r_left == 16'd2 && r_pos == CountW'(2)) begin
                        t_we = 1'b1; t_wa = r_a[RegIdxW-1:0]; t_wd = r_b;
                    end
                    if (r_pos == CountW'(5)) n_state = ST_CRC_LO;
                end
            end
            ST_CRC_LO: begin
                emit = 1'b1; e_byte = r_tcrc[7:0];
                if (out_free) n_state = ST_CRC_HI;
            end
            ST_CRC_HI: begin
                emit = 1'b1; e_byte = r_tcrc[15:8]; e_last = 1'b1;
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        if (emit && out_free) begin
            n_ovalid = 1'b1;
            n_odata.tx_byte = e_byte;
            n_odata.last = e_last;
            n_pos = r_pos + 1'b1;
            if (r_state != ST_CRC_LO && r_state != ST_CRC_HI)
                n_tcrc = crc_byte(r_tcrc, e_byte);
            if (r_pos < CountW'(FrameDepth)) begin
                f_we = 1'b1; f_wa = r_pos[FrameIdxW-1:0]; f_wd = e_byte;
            end
        end
    end

    // Write-register store happens on first echo byte, before a is shifted.
    // (handled when r_pos == 2, i.e. first echo byte)

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled transfer changed");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("accepted while busy");
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CRC_HI && out_free) |=> (r_state == ST_IDLE && o_data.last))
        else $error("reply did not end");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(FrameDepth)) else $error("count overrun");
endmodule
`default_nettype wire
